// ----- sv/mepq_pkg.sv -----
// ----------------------------------------------------------------------------
// mepq_pkg
// Types and constants shared by the motion event poll qualifier files.
// ----------------------------------------------------------------------------
`default_nettype none

package mepq_pkg;

  // status codes
  localparam logic [7:0] BusFailCode = 8'hFF;
  localparam logic [7:0] MotionMask  = 8'h6A;  // 0x40 | 0x2A

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegPollInterval = 8'd0;
  localparam logic [CfgIdxW-1:0] RegStreakLimit  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegCountSpacing = 8'd2;
  localparam logic [CfgIdxW-1:0] RegQuiet        = 8'd3;

  // register reset values
  localparam logic [15:0] PollIntervalRst = 16'd50;
  localparam logic [7:0]  StreakLimitRst  = 8'd5;
  localparam logic [15:0] CountSpacingRst = 16'd500;
  localparam logic [31:0] QuietRst        = 32'd60000;

  localparam logic [7:0] StreakMax = 8'hFF;

  typedef struct packed {
    logic [15:0] poll_interval_ms;
    logic [7:0]  bad_streak_limit;
    logic [15:0] count_spacing_ms;
    logic [31:0] quiet_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [7:0]  status_byte;
    logic        sensor_ready;
  } item_t;

  typedef struct packed {
    logic        polled;
    logic        reinit_request;
    logic [31:0] event_count;
    logic [31:0] last_motion_ms;
    logic [7:0]  failure_streak;
    logic [31:0] reinit_count;
    logic        is_quiet;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/mepq_if.sv -----
// ----------------------------------------------------------------------------
// mepq interfaces
// Poll offer, result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface mepq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [7:0]  status_byte;
  logic        sensor_ready;

  modport source (output valid, output now_ms, output status_byte,
                  output sensor_ready, input ready);
  modport sink   (input valid, input now_ms, input status_byte,
                  input sensor_ready, output ready);
endinterface

interface mepq_out_if;
  logic        valid;
  logic        ready;
  logic        polled;
  logic        reinit_request;
  logic [31:0] event_count;
  logic [31:0] last_motion_ms;
  logic [7:0]  failure_streak;
  logic [31:0] reinit_count;
  logic        is_quiet;

  modport source (output valid, output polled, output reinit_request,
                  output event_count, output last_motion_ms,
                  output failure_streak, output reinit_count,
                  output is_quiet, input ready);
  modport sink   (input valid, input polled, input reinit_request,
                  input event_count, input last_motion_ms,
                  input failure_streak, input reinit_count,
                  input is_quiet, output ready);
endinterface

interface mepq_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/motion_event_poll_qualifier.sv -----
// ----------------------------------------------------------------------------
// motion_event_poll_qualifier
// Qualifies sensor poll offers and tracks failures, reinits and motion events.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_i      in    valid/ready    now_ms, status_byte, sensor_ready
//  out_o     out   valid/ready    polled .. is_quiet, one result per offer
//  cfg_i     in    valid/ready    index, data (always ready)
//
// One offer per cycle while out_o is not stalled; each offer passes through
// the input register, then the state update and result register, to result valid.
// Reset clears all state and loads the register defaults.
// A stalled result holds; the input register keeps taking offers until it
// is also full, then in_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_event_poll_qualifier (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mepq_in_if.sink    in_i,
  mepq_out_if.source out_o,
  mepq_cfg_if.sink   cfg_i
);
  import mepq_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld_q;
  result_t res, res_q;
  logic    res_vld_q;
  logic    advance;

  // item moves on when the result register is free or being drained
  assign advance    = item_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready = !item_vld_q || advance;

  mepq_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  mepq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .commit_i (advance),
    .result_o (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.now_ms       <= in_i.now_ms;
      item_q.status_byte  <= in_i.status_byte;
      item_q.sensor_ready <= in_i.sensor_ready;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = res_vld_q;
  assign out_o.polled         = res_q.polled;
  assign out_o.reinit_request = res_q.reinit_request;
  assign out_o.event_count    = res_q.event_count;
  assign out_o.last_motion_ms = res_q.last_motion_ms;
  assign out_o.failure_streak = res_q.failure_streak;
  assign out_o.reinit_count   = res_q.reinit_count;
  assign out_o.is_quiet       = res_q.is_quiet;

endmodule

`default_nettype wire

// ----- sv/mepq_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mepq_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mepq_cfg_regs (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  mepq_cfg_if.sink      cfg_i,
  output mepq_pkg::cfg_t cfg_o
);
  import mepq_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // always ready for a transfer
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_i.index)
        RegPollInterval: cfg_d.poll_interval_ms = cfg_i.data[15:0];
        RegStreakLimit:  cfg_d.bad_streak_limit = cfg_i.data[7:0];
        RegCountSpacing: cfg_d.count_spacing_ms = cfg_i.data[15:0];
        RegQuiet:        cfg_d.quiet_ms         = cfg_i.data;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_interval_ms <= PollIntervalRst;
      cfg_q.bad_streak_limit <= StreakLimitRst;
      cfg_q.count_spacing_ms <= CountSpacingRst;
      cfg_q.quiet_ms         <= QuietRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/mepq_core.sv -----
// ----------------------------------------------------------------------------
// mepq_core
// Poll qualification, failure streak and motion event state, one item a cycle while commit_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mepq_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mepq_pkg::cfg_t    cfg_i,
  input  wire mepq_pkg::item_t   item_i,
  input  wire logic              commit_i,
  output mepq_pkg::result_t      result_o
);
  import mepq_pkg::*;

  logic [31:0] last_poll_q, last_poll_d;
  logic [31:0] last_motion_q, last_motion_d;
  logic [31:0] last_counted_q, last_counted_d;
  logic [31:0] events_q, events_d;
  logic [7:0]  bad_q, bad_d;
  logic [31:0] reinits_q, reinits_d;

  logic [31:0] poll_age, count_age, motion_age;
  logic        take, fail, motion, spaced, reinit;
  logic [7:0]  bad_inc;

  // wrapping time differences
  assign poll_age  = item_i.now_ms - last_poll_q;
  assign count_age = item_i.now_ms - last_counted_q;

  assign take   = item_i.sensor_ready &&
                  (poll_age > {16'd0, cfg_i.poll_interval_ms});
  assign fail   = (item_i.status_byte == BusFailCode);
  assign motion = ((item_i.status_byte & MotionMask) != 8'd0);
  assign spaced = (last_counted_q == 32'd0) ||
                  (count_age >= {16'd0, cfg_i.count_spacing_ms});

  // saturating streak increment and limit check
  assign bad_inc = (bad_q < StreakMax) ? bad_q + 8'd1 : bad_q;
  assign reinit  = take && fail && (bad_inc >= cfg_i.bad_streak_limit);

  // next state
  always_comb begin
    last_poll_d    = last_poll_q;
    last_motion_d  = last_motion_q;
    last_counted_d = last_counted_q;
    events_d       = events_q;
    bad_d          = bad_q;
    reinits_d      = reinits_q;
    if (take) begin
      last_poll_d = item_i.now_ms;
      if (fail) begin
        if (reinit) begin
          bad_d     = 8'd0;
          reinits_d = reinits_q + 32'd1;
        end else begin
          bad_d = bad_inc;
        end
      end else begin
        bad_d = 8'd0;
        if (motion) begin
          last_motion_d = item_i.now_ms;
          if (spaced) begin
            last_counted_d = item_i.now_ms;
            events_d       = events_q + 32'd1;
          end
        end
      end
    end
  end

  // quiet flag from the updated motion time
  assign motion_age = item_i.now_ms - last_motion_d;

  always_comb begin
    result_o.polled         = take;
    result_o.reinit_request = reinit;
    result_o.event_count    = events_d;
    result_o.last_motion_ms = last_motion_d;
    result_o.failure_streak = bad_d;
    result_o.reinit_count   = reinits_d;
    result_o.is_quiet       = (last_motion_d == 32'd0) || (motion_age >= cfg_i.quiet_ms);
  end

  // state registers, updated when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_poll_q    <= 32'd0;
      last_motion_q  <= 32'd0;
      last_counted_q <= 32'd0;
      events_q       <= 32'd0;
      bad_q          <= 8'd0;
      reinits_q      <= 32'd0;
    end else if (commit_i) begin
      last_poll_q    <= last_poll_d;
      last_motion_q  <= last_motion_d;
      last_counted_q <= last_counted_d;
      events_q       <= events_d;
      bad_q          <= bad_d;
      reinits_q      <= reinits_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mepq_checker.sv -----
// ----------------------------------------------------------------------------
// mepq_checker
// Port-level checks on the result channel of the poll qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

module mepq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        polled_i,
  input wire logic        reinit_request_i,
  input wire logic [31:0] last_motion_ms_i,
  input wire logic [7:0]  failure_streak_i,
  input wire logic        is_quiet_i
);

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(reinit_request_i) &&
      $stable(last_motion_ms_i) && $stable(failure_streak_i))
    else $error("result changed while stalled");

  // a reinit request only comes from a taken poll
  a_reinit_polled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && reinit_request_i |-> polled_i)
    else $error("reinit request without a poll");

  // a reinit clears the failure streak
  a_reinit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && reinit_request_i |-> failure_streak_i == 8'd0)
    else $error("streak not cleared on reinit");

  // never quiet-free without any motion seen
  a_quiet_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_motion_ms_i == 32'd0 |-> is_quiet_i)
    else $error("not quiet though no motion seen");

endmodule

bind motion_event_poll_qualifier mepq_checker u_mepq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .polled_i         (out_o.polled),
  .reinit_request_i (out_o.reinit_request),
  .last_motion_ms_i (out_o.last_motion_ms),
  .failure_streak_i (out_o.failure_streak),
  .is_quiet_i       (out_o.is_quiet)
);

`default_nettype wire
